/* hdl/lzd_pkg.sv */
`timescale 1ns / 1ps

package lzd_pkg;

  // Fixed field widths of the compressed format.
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned DIST_W     = 12;
  localparam int unsigned LEN_CODE_W = 4;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned ITEMS_W    = 4;

  localparam logic [LEN_W-1:0]   MIN_MATCH   = LEN_W'(3);
  localparam logic [ITEMS_W-1:0] GROUP_ITEMS = ITEMS_W'(8);

  // Kind of work handed from the parser to the copy engine.
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_LITERAL,
    CMD_COPY
  } cmd_kind_t;

  typedef struct packed {
    logic                  fire;
    cmd_kind_t             kind;
    logic [BYTE_W-1:0]     literal;
    logic [LEN_W-1:0]      len;
    logic [DIST_W-1:0]     dist_m1;
    logic                  block_end;
  } cmd_t;

endpackage

/* hdl/lzd_parser.sv */
`timescale 1ns / 1ps

module lzd_parser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_fire,
  input  logic [lzd_pkg::BYTE_W-1:0]   in_byte,
  input  logic                         block_end,
  output lzd_pkg::cmd_t                cmd
);
  import lzd_pkg::*;

  logic                 want_flag;
  logic [BYTE_W-1:0]    flag_bits;
  logic [ITEMS_W-1:0]   items_left;
  logic                 want_high;
  logic [BYTE_W-1:0]    code_low;

  logic [ITEMS_W-1:0]   items_dec;
  logic [2*BYTE_W-1:0]  code;

  assign items_dec = items_left - ITEMS_W'(1);
  assign code      = {in_byte, code_low};

  // Decode the current byte according to where the parse stands.
  always_comb begin
    cmd           = '0;
    cmd.fire      = in_fire;
    cmd.kind      = CMD_NONE;
    cmd.literal   = in_byte;
    cmd.len       = MIN_MATCH + LEN_W'(code[2*BYTE_W-1 -: LEN_CODE_W]);
    cmd.dist_m1   = code[DIST_W-1:0];
    cmd.block_end = block_end;
    if (!want_flag) begin
      if (!flag_bits[0]) begin
        cmd.kind = CMD_LITERAL;
      end else if (want_high) begin
        cmd.kind = CMD_COPY;
      end
    end
  end

  // Parse state: flag group, held low code byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      want_flag  <= 1'b1;
      flag_bits  <= '0;
      items_left <= '0;
      want_high  <= 1'b0;
      code_low   <= '0;
    end else if (in_fire) begin
      if (block_end) begin
        want_flag  <= 1'b1;
        flag_bits  <= '0;
        items_left <= '0;
        want_high  <= 1'b0;
        code_low   <= '0;
      end else if (want_flag) begin
        flag_bits  <= in_byte;
        items_left <= GROUP_ITEMS;
        want_flag  <= 1'b0;
      end else if (flag_bits[0] && !want_high) begin
        code_low  <= in_byte;
        want_high <= 1'b1;
      end else begin
        want_high  <= 1'b0;
        code_low   <= '0;
        flag_bits  <= flag_bits >> 1;
        items_left <= items_dec;
        if (items_dec == '0) begin
          want_flag <= 1'b1;
        end
      end
    end
  end

endmodule

/* hdl/lzd_copy.sv */
`timescale 1ns / 1ps

module lzd_copy #(
  parameter int unsigned HISTORY_DEPTH = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lzd_pkg::cmd_t                cmd,
  output logic                         idle,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lzd_pkg::BYTE_W-1:0]   out_byte,
  output logic                         out_last
);
  import lzd_pkg::*;

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);

  logic [BYTE_W-1:0] hist_mem [HISTORY_DEPTH];

  // Write pointer, and the count of history entries ever written. Writes run
  // upwards from zero, so the written entries are always the lowest ones.
  logic [AW-1:0]     wp;
  logic [AW:0]       fill;
  logic [AW:0]       wp_inc;

  // Copy sequencer.
  logic [AW-1:0]     rd_addr;
  logic [LEN_W-1:0]  cnt;
  logic              end_pend;

  // Byte waiting between the memory read and the output register.
  logic              pend;
  logic              pend_zero;
  logic              pend_fwd;
  logic [BYTE_W-1:0] pend_fwd_data;
  logic              pend_last;
  logic [BYTE_W-1:0] mem_q;
  logic [BYTE_W-1:0] pend_val;

  logic              move;
  logic              issue;
  logic              fwd_hit;
  logic              in_range;

  assign pend_val = pend_zero ? '0 : (pend_fwd ? pend_fwd_data : mem_q);
  assign move     = pend && (!out_valid || out_ready);
  assign issue    = (cnt != '0) && (!pend || move);
  assign fwd_hit  = move && (rd_addr == wp);
  assign in_range = {1'b0, rd_addr} < fill;
  assign wp_inc   = {1'b0, wp} + (AW+1)'(1);
  assign idle     = !pend && (cnt == '0);

  // History memory: one write at the output side, one registered read.
  always_ff @(posedge clk) begin
    if (move) begin
      hist_mem[wp] <= pend_val;
    end
    if (issue) begin
      mem_q <= hist_mem[rd_addr];
    end
  end

  // Pending byte payload.
  always_ff @(posedge clk) begin
    if (cmd.fire && cmd.kind == CMD_LITERAL) begin
      pend_zero     <= 1'b0;
      pend_fwd      <= 1'b1;
      pend_fwd_data <= cmd.literal;
      pend_last     <= 1'b1;
    end else if (issue) begin
      pend_zero     <= !in_range && !fwd_hit;
      pend_fwd      <= fwd_hit;
      pend_fwd_data <= pend_val;
      pend_last     <= (cnt == LEN_W'(1));
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (move) begin
      out_byte <= pend_val;
      out_last <= pend_last;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      fill      <= '0;
      rd_addr   <= '0;
      cnt       <= '0;
      end_pend  <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (issue) begin
        pend    <= 1'b1;
        cnt     <= cnt - LEN_W'(1);
        rd_addr <= rd_addr + AW'(1);
      end else if (move) begin
        pend <= 1'b0;
      end

      if (move) begin
        if (wp_inc > fill) begin
          fill <= wp_inc;
        end
        if (pend_last && end_pend) begin
          wp       <= '0;
          end_pend <= 1'b0;
        end else begin
          wp <= wp_inc[AW-1:0];
        end
      end

      // New work from the parser; only taken while idle.
      if (cmd.fire) begin
        unique case (cmd.kind)
          CMD_LITERAL: begin
            pend     <= 1'b1;
            end_pend <= cmd.block_end;
          end
          CMD_COPY: begin
            cnt      <= cmd.len;
            rd_addr  <= wp - AW'(cmd.dist_m1) - AW'(1);
            end_pend <= cmd.block_end;
          end
          default: begin
            if (cmd.block_end) begin
              wp <= '0;
            end
          end
        endcase
      end
    end
  end

endmodule

/* hdl/lzss_byte_decompressor.sv */
`timescale 1ns / 1ps

// LZSS decompressor with a 4096-byte history window.
// Input stream s_*: one compressed byte per beat (flag byte, literal or code
// byte); s_tlast marks the last byte of a block, after which the parse and
// the history write pointer restart while the history contents are kept.
// Output stream m_*: one decompressed byte per beat; m_tlast is set on the
// last byte produced by an input beat.
// A flag byte or the first byte of a code gives no output. A literal gives
// one byte, which passes the pending byte register and then the output
// register. The second byte of a code gives 3 to 18 bytes at one byte a
// cycle while the receiver does not stall, each read from the history
// memory; the history memory sustains one read and one write per cycle.
// A new input beat is taken once the previous one has all its bytes at or
// past the output register.
// Reset clears the parse and the pointers; history entries never written
// since reset read as zero, tracked by a fill count, so no clearing pass is
// needed and the block is ready in the first cycle after reset.
// When the receiver stalls, the output register holds its byte, one more byte
// may wait behind it, and the copy and the input side stop.

module lzss_byte_decompressor #(
  parameter int unsigned HISTORY_DEPTH = 4096
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // block_end
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast    // out_last
);
  import lzd_pkg::*;

  cmd_t cmd;
  logic copy_idle;
  logic in_fire;

  assign s_tready = copy_idle;
  assign in_fire  = s_tvalid && s_tready;

  lzd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_byte   (s_tdata),
    .block_end (s_tlast),
    .cmd       (cmd)
  );

  lzd_copy #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_copy (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .idle      (copy_idle),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

/* hdl/lzd_checker.sv */
`timescale 1ns / 1ps

module lzd_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [7:0] s_tdata,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // No output beat is offered straight after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // A stalled output beat holds its contents.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output beat changed");

  // While a run is still being delivered, no new compressed byte is taken.
  a_run_blocks_input: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input taken in the middle of a run");

  // A beat accepted at the input never shows at the output in the next cycle.
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
    else $error("output appeared too early");

endmodule

bind lzss_byte_decompressor lzd_checker u_lzd_checker (.*);
